// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the double-ended queue.
// Holds the command codes and the sequencer state type; no dependencies.
package deq_pkg;

  // Command codes carried on the operation field
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Double-ended queue of signed words held in a ring buffer memory.
// Depends on deq_pkg for command codes and the state type.
//
// Usage: one command transaction enters on in_valid/in_stall (operation,
// value) and exactly one result transaction leaves on out_valid/out_stall.
// Commands: no-op, push front, push back, pop front, pop back; unused codes
// act as no-ops. A push to a full queue is dropped with overflow set; a pop
// from an empty queue returns -1 with pop_done low. Every result carries the
// occupancy, an empty flag and the front and back words (-1 when empty).
// Pushes, no-ops, failed pops and pops that leave the queue empty load the
// result register in the cycle after acceptance; other pops first read the new
// front or back word from the synchronous element memory in the fetch state.
// Throughput is one command per cycle unless out_stall or a fetch holds input.
// The front and back words are cached in registers so a push never reads.
// Reset clears head, tail, count, out_valid and the sequencer; the memory keeps no
// reset and needs no clearing pass, since only occupied slots are read.
// A new command is taken while a finished result waits, as long as that
// result is taken in the same cycle; while out_stall holds a waiting result,
// in_stall holds.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   operation,
  input  logic signed [DATA_WIDTH-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] popped_value,
  output logic                         pop_done,
  output logic                         overflow,
  output logic [CW-1:0]                occupancy,
  output logic                         is_empty,
  output logic signed [DATA_WIDTH-1:0] front_value,
  output logic signed [DATA_WIDTH-1:0] back_value
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic signed [DATA_WIDTH-1:0] front_reg, front_next;
  logic signed [DATA_WIDTH-1:0] back_reg, back_next;
  logic signed [DATA_WIDTH-1:0] pend_popped, pend_popped_next;
  logic pend_front, pend_front_next;

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic rd_en, wr_en;
  logic signed [DATA_WIDTH-1:0] wr_data;

  logic accept, load_out;
  logic signed [DATA_WIDTH-1:0] res_popped, res_front, res_back;
  logic res_done, res_ovf;
  logic full, empty;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == LAST_SLOT) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    ring_prev = (i == '0) ? LAST_SLOT : i - AW'(1);
  endfunction

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);

  // Take a command only when idle and the output register is free or draining
  assign in_stall = !((state == ST_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  // Decode the command and plan state updates, memory accesses and result
  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    front_next       = front_reg;
    back_next        = back_reg;
    pend_popped_next = pend_popped;
    pend_front_next  = pend_front;
    rd_en            = 1'b0;
    rd_addr          = head;
    wr_en            = 1'b0;
    wr_addr          = tail;
    wr_data          = value;
    load_out         = 1'b0;
    res_popped       = '1;
    res_done         = 1'b0;
    res_ovf          = 1'b0;
    res_front        = '1;
    res_back         = '1;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (op_t'(operation))
            OP_PUSH_FRONT: begin
              if (full) begin
                res_ovf = 1'b1;
              end else begin
                head_next  = ring_prev(head);
                wr_en      = 1'b1;
                wr_addr    = ring_prev(head);
                count_next = count + CW'(1);
                front_next = value;
                if (empty) begin
                  back_next = value;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res_ovf = 1'b1;
              end else begin
                tail_next  = ring_next(tail);
                wr_en      = 1'b1;
                wr_addr    = tail;
                count_next = count + CW'(1);
                back_next  = value;
                if (empty) begin
                  front_next = value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (!empty) begin
                res_popped = front_reg;
                res_done   = 1'b1;
                head_next  = ring_next(head);
                count_next = count - CW'(1);
                if (count != CW'(1)) begin
                  // Fetch the new front word before answering
                  load_out         = 1'b0;
                  rd_en            = 1'b1;
                  rd_addr          = ring_next(head);
                  pend_popped_next = front_reg;
                  pend_front_next  = 1'b1;
                  state_next       = ST_FETCH;
                end
              end
            end
            OP_POP_BACK: begin
              if (!empty) begin
                res_popped = back_reg;
                res_done   = 1'b1;
                tail_next  = ring_prev(tail);
                count_next = count - CW'(1);
                if (count != CW'(1)) begin
                  // Fetch the new back word before answering
                  load_out         = 1'b0;
                  rd_en            = 1'b1;
                  rd_addr          = ring_prev(ring_prev(tail));
                  pend_popped_next = back_reg;
                  pend_front_next  = 1'b0;
                  state_next       = ST_FETCH;
                end
              end
            end
            default: begin
            end
          endcase
          if (count_next != '0) begin
            res_front = front_next;
            res_back  = back_next;
          end
        end
      end
      ST_FETCH: begin
        // Read data is back: refresh the cached end and answer
        load_out   = 1'b1;
        res_popped = pend_popped;
        res_done   = 1'b1;
        if (pend_front) begin
          front_next = rd_data;
        end else begin
          back_next = rd_data;
        end
        res_front  = front_next;
        res_back   = back_next;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Element memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Cached end words and pending pop payload
  always_ff @(posedge clk) begin
    front_reg   <= front_next;
    back_reg    <= back_next;
    pend_popped <= pend_popped_next;
    pend_front  <= pend_front_next;
  end

  // Output register: load a result, drop valid once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      popped_value <= res_popped;
      pop_done     <= res_done;
      overflow     <= res_ovf;
      occupancy    <= count_next;
      is_empty     <= (count_next == '0);
      front_value  <= res_front;
      back_value   <= res_back;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("element count exceeds depth");

  a_ring_wrap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL_COUNT) |-> (head == tail))
    else $error("head and tail disagree with empty or full count");

  a_fetch_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> !out_valid)
    else $error("output register busy while a pop fetch completes");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pop_done && overflow))
    else $error("result reports both a pop and an overflow");

  a_fetch_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |=> (state == ST_IDLE))
    else $error("pop fetch did not finish in one cycle");

endmodule

// ===== sim/double_ended_queue_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: commands in, one result per command out.
// Depends on deq_pkg and the double_ended_queue RTL; keeps its own ring buffer to predict.
module double_ended_queue_test
  import deq_pkg::*;
();

  localparam int DEPTH = 1024;
  localparam int DW = 32;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [DW-1:0] NO_WORD = '1;
  // Codes past the last command; the block treats them as no-ops
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [DW-1:0] popped;
    logic          done;
    logic          ovf;
    logic [CW-1:0] occ;
    logic          empty;
    logic [DW-1:0] front;
    logic [DW-1:0] back;
  } deq_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           operation = OP_NONE;
  logic signed [DW-1:0] value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] popped_value;
  logic                 pop_done;
  logic                 overflow;
  logic [CW-1:0]        occupancy;
  logic                 is_empty;
  logic signed [DW-1:0] front_value;
  logic signed [DW-1:0] back_value;

  // Mirror of the ring buffer
  logic [DW-1:0] ring_words [DEPTH];
  logic [AW-1:0] ring_head = '0;
  logic [AW-1:0] ring_tail = '0;
  int unsigned   ring_count = 0;

  deq_result_t predicted_results [$];
  int          errors = 0;
  int unsigned cycle_count = 0;
  int          hold_off_len = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .pop_done     (pop_done),
    .overflow     (overflow),
    .occupancy    (occupancy),
    .is_empty     (is_empty),
    .front_value  (front_value),
    .back_value   (back_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Apply one command to the mirror and queue the result it must produce
  function automatic void deque_apply(input logic [2:0] op, input logic [DW-1:0] word);
    deq_result_t r;
    r.popped = NO_WORD;
    r.done = 1'b0;
    r.ovf = 1'b0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          r.ovf = 1'b1;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            ring_head = ring_head - 1'b1;
            ring_words[ring_head] = word;
          end else begin
            ring_words[ring_tail] = word;
            ring_tail = ring_tail + 1'b1;
          end
          ring_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (ring_count != 0) begin
          if (op == OP_POP_FRONT) begin
            r.popped = ring_words[ring_head];
            ring_head = ring_head + 1'b1;
          end else begin
            ring_tail = ring_tail - 1'b1;
            r.popped = ring_words[ring_tail];
          end
          ring_count--;
          r.done = 1'b1;
        end
      end
      default: ;
    endcase
    r.occ = CW'(ring_count);
    r.empty = (ring_count == 0);
    if (ring_count == 0) begin
      r.front = NO_WORD;
      r.back = NO_WORD;
    end else begin
      r.front = ring_words[ring_head];
      r.back = ring_words[AW'(ring_tail - 1'b1)];
    end
    predicted_results = {predicted_results, r};
  endfunction

  // Offer one command after a random gap; predict once it is accepted
  task automatic send_cmd(input logic [2:0] op, input logic [DW-1:0] word);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    value <= word;
    do @(posedge clk); while (in_stall);
    deque_apply(op, word);
  endtask

  task automatic check_field(input string name, input logic [DW-1:0] want,
                             input logic [DW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    deq_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual popped_value %h",
                 $time, popped_value);
        errors++;
      end else begin
        want = predicted_results[0];
        predicted_results.delete(0);
        check_field("popped_value", want.popped, popped_value);
        check_field("pop_done", want.done, pop_done);
        check_field("overflow", want.ovf, overflow);
        check_field("occupancy", want.occ, occupancy);
        check_field("is_empty", want.empty, is_empty);
        check_field("front_value", want.front, front_value);
        check_field("back_value", want.back, back_value);
      end
    end
  end

  // Take results with random stalls; hold off for a long stretch on request
  initial begin : result_taker
    int pause;
    @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        pause = hold_off_len;
        hold_off_len = 0;
      end else begin
        pause = take_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Empty pops, no-ops, word extremes, pops that empty the queue
  task automatic test_directed();
    send_cmd(OP_POP_FRONT, $urandom);
    send_cmd(OP_POP_BACK, $urandom);
    send_cmd(OP_NONE, $urandom);
    send_cmd(OP_SPARE_LO, $urandom);
    send_cmd(3'(OP_SPARE_LO + 1), $urandom);
    send_cmd(OP_SPARE_HI, $urandom);
    send_cmd(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_cmd(OP_PUSH_BACK, 32'h8000_0000);
    send_cmd(OP_PUSH_FRONT, 32'hffff_ffff);
    send_cmd(OP_PUSH_BACK, 32'h0000_0000);
    send_cmd(OP_NONE, 32'h1234_5678);
    send_cmd(OP_SPARE_HI, 32'h8765_4321);
    send_cmd(OP_POP_FRONT, $urandom);
    send_cmd(OP_POP_BACK, $urandom);
    send_cmd(OP_POP_FRONT, $urandom);
    send_cmd(OP_POP_BACK, $urandom);
    send_cmd(OP_POP_FRONT, $urandom);
    send_cmd(OP_PUSH_BACK, 32'h5555_5555);
    send_cmd(OP_PUSH_BACK, 32'haaaa_aaaa);
    send_cmd(OP_POP_BACK, $urandom);
    send_cmd(OP_POP_BACK, $urandom);
    send_cmd(OP_PUSH_FRONT, 32'hdead_beef);
    send_cmd(OP_POP_FRONT, $urandom);
    send_cmd(OP_POP_BACK, $urandom);
  endtask

  // Fill to capacity under a long receiver hold-off, then push into a full queue
  task automatic test_fill_and_overflow();
    hold_off_len = HOLD_OFF_CYCLES;
    while (ring_count < DEPTH)
      send_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
    send_cmd(OP_PUSH_FRONT, $urandom);
    send_cmd(OP_PUSH_BACK, $urandom);
    send_cmd(OP_PUSH_FRONT, 32'h8000_0000);
    send_cmd(OP_PUSH_BACK, 32'h7fff_ffff);
    send_cmd(OP_POP_FRONT, $urandom);
    send_cmd(OP_PUSH_BACK, $urandom);
    send_cmd(OP_PUSH_FRONT, $urandom);
    send_cmd(OP_POP_BACK, $urandom);
    send_cmd(OP_PUSH_FRONT, $urandom);
    send_cmd(OP_NONE, $urandom);
  endtask

  // Pop at random ends until empty, with a few no-ops mixed in
  task automatic test_drain();
    logic [2:0] op;
    while (ring_count != 0) begin
      if ($urandom_range(0, 99) < 3) begin
        op = 3'($urandom_range(OP_SPARE_LO - 1, OP_SPARE_HI));
        if (op < OP_SPARE_LO) op = OP_NONE;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_cmd(op, $urandom);
    end
  endtask

  // Balanced mix near empty: pops on empty and pops that empty the queue
  task automatic test_low_occupancy();
    logic [2:0] op;
    int pick;
    repeat (100) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        op = 3'($urandom_range(OP_SPARE_LO - 1, OP_SPARE_HI));
        if (op < OP_SPARE_LO) op = OP_NONE;
      end else if (pick < 60) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_cmd(op, $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_overflow();
    test_drain();
    test_low_occupancy();
    in_valid <= 1'b0;
    // Wait out the last results, then watch for strays
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
